[sv/framed_packet_receiver_top_defines.svh]
// ----------------------------------------------------------------------------
// Framed packet receiver assertion macros
// Shared assertion forms for the checker; clock and reset are taken by name.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_TOP_DEFINES_SVH

// Clocked check, quiet while reset is high
`define FPR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset
`define FPR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Widths, phase codes, result codes and the result payload type.
// ----------------------------------------------------------------------------
package fpr_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int INDEX_W = 15;
   localparam int KIND_W  = 2;
   localparam int CAUSE_W = 2;

   // Parse phases of a frame
   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_COMMAND = 3'd2,
      PH_DATA    = 3'd3,
      PH_CHECK   = 3'd4,
      PH_END     = 3'd5
   } phase_type;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   // Reject causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_START = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_SUM   = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_END   = 2'd3;

   // Reply bytes
   localparam logic [BYTE_W-1:0] REPLY_NONE = 8'h00;
   localparam logic [BYTE_W-1:0] REPLY_ACK  = 8'h2D;
   localparam logic [BYTE_W-1:0] REPLY_NAK  = 8'hA5;

   // Control register indexes and reset values
   localparam logic CSR_START_WORD = 1'b0;
   localparam logic CSR_END_WORD   = 1'b1;

   localparam logic [WORD_W-1:0] START_WORD_RESET = 16'h1BE4;
   localparam logic [WORD_W-1:0] END_WORD_RESET   = 16'hE41B;

   // One result beat
   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [WORD_W-1:0]  frame_command;
      logic [WORD_W-1:0]  frame_length;
      logic [WORD_W-1:0]  data_word;
      logic [INDEX_W-1:0] data_index;
      logic [CAUSE_W-1:0] error_cause;
      logic [BYTE_W-1:0]  reply_byte;
   } rsp_type;

endpackage

[sv/fpr_channels.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver channels
// Valid/ready stream interfaces for received bytes and for results.
// ----------------------------------------------------------------------------
interface fpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] frame_command;
   logic [15:0] frame_length;
   logic [15:0] data_word;
   logic [14:0] data_index;
   logic [1:0]  error_cause;
   logic [7:0]  reply_byte;

   modport source (output valid, output result_kind, output frame_command,
                   output frame_length, output data_word, output data_index,
                   output error_cause, output reply_byte, input ready);
   modport sink (input valid, input result_kind, input frame_command,
                 input frame_length, input data_word, input data_index,
                 input error_cause, input reply_byte, output ready);
endinterface

[sv/fpr_parser.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver parser
// Pairs bytes into words, walks the frame phases, keeps the checksum and
// forms at most one result per byte pair.
// ----------------------------------------------------------------------------
module fpr_parser import fpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_take,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic [WORD_W-1:0] start_word,
   input  logic [WORD_W-1:0] end_word,
   output logic              res_valid,
   output rsp_type           res
);

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   low_ff;
   logic                high_ff;
   logic [WORD_W-1:0]   len_ff;
   logic [INDEX_W-1:0]  remain_ff;
   logic [INDEX_W-1:0]  pos_ff;
   logic [WORD_W-1:0]   sum_ff;
   logic [WORD_W-1:0]   cmd_ff;

   logic [WORD_W-1:0]   word;
   logic                pair;
   logic [WORD_W-1:0]   pair_sum;
   logic [INDEX_W-1:0]  remain_dec;

   assign word       = {in_byte, low_ff};
   assign pair       = in_valid && high_ff;
   assign pair_sum   = sum_ff + {{(WORD_W-BYTE_W){1'b0}}, low_ff}
                              + {{(WORD_W-BYTE_W){1'b0}}, in_byte};
   assign remain_dec = remain_ff - {{(INDEX_W-1){1'b0}}, 1'b1};

   // Next phase on a completed word
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LENGTH:  phase_in = PH_COMMAND;
         PH_COMMAND: phase_in = (remain_ff != '0) ? PH_DATA : PH_CHECK;
         PH_DATA:    phase_in = (remain_dec != '0) ? PH_DATA : PH_CHECK;
         PH_CHECK:   phase_in = (word == sum_ff) ? PH_END : PH_START;
         PH_END:     phase_in = PH_START;
         default:    phase_in = (word == start_word) ? PH_LENGTH : PH_START;
      endcase
   end

   // Result for a completed word
   always_comb begin
      res_valid         = 1'b0;
      res.result_kind   = KIND_DATA;
      res.frame_command = cmd_ff;
      res.frame_length  = len_ff;
      res.data_word     = '0;
      res.data_index    = '0;
      res.error_cause   = CAUSE_NONE;
      res.reply_byte    = REPLY_NONE;
      if (pair) begin
         unique case (phase_ff)
            PH_LENGTH, PH_COMMAND: begin
               res_valid = 1'b0;
            end
            PH_DATA: begin
               res_valid      = 1'b1;
               res.data_word  = word;
               res.data_index = pos_ff;
            end
            PH_CHECK: begin
               if (word != sum_ff) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_REJECT;
                  res.error_cause = CAUSE_SUM;
                  res.reply_byte  = REPLY_NAK;
               end
            end
            PH_END: begin
               res_valid = 1'b1;
               if (word != end_word) begin
                  res.result_kind = KIND_REJECT;
                  res.error_cause = CAUSE_END;
                  res.reply_byte  = REPLY_NAK;
               end else begin
                  res.result_kind = KIND_ACCEPT;
                  res.reply_byte  = REPLY_ACK;
               end
            end
            default: begin
               if (word != start_word) begin
                  res_valid         = 1'b1;
                  res.result_kind   = KIND_REJECT;
                  res.frame_command = '0;
                  res.frame_length  = '0;
                  res.error_cause   = CAUSE_START;
                  res.reply_byte    = REPLY_NAK;
               end
            end
         endcase
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         low_ff    <= '0;
         high_ff   <= 1'b0;
         len_ff    <= '0;
         remain_ff <= '0;
         pos_ff    <= '0;
         sum_ff    <= '0;
         cmd_ff    <= '0;
      end else if (in_take) begin
         if (!high_ff) begin
            low_ff  <= in_byte;
            high_ff <= 1'b1;
         end else begin
            high_ff  <= 1'b0;
            phase_ff <= phase_in;
            unique case (phase_ff)
               PH_LENGTH: begin
                  len_ff    <= word;
                  remain_ff <= word[WORD_W-1:1];
                  pos_ff    <= '0;
                  sum_ff    <= '0;
               end
               PH_COMMAND: begin
                  cmd_ff <= word;
                  sum_ff <= pair_sum;
               end
               PH_DATA: begin
                  sum_ff    <= pair_sum;
                  pos_ff    <= pos_ff + {{(INDEX_W-1){1'b0}}, 1'b1};
                  remain_ff <= remain_dec;
               end
               default: begin
                  sum_ff <= sum_ff;
               end
            endcase
         end
      end
   end

endmodule

[sv/fpr_rsp_queue.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver result queue
// Output register plus skid entry, so a new result can land while the
// head beat waits for the receiver.
// ----------------------------------------------------------------------------
module fpr_rsp_queue import fpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    pop;

   assign pop       = head_valid_ff && out_ready;
   assign full      = head_valid_ff && skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   // Head and skid update
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         head_in       = skid_valid_ff ? skid_ff : push_data;
         head_valid_in = skid_valid_ff || push;
         skid_in       = push_data;
         skid_valid_in = skid_valid_ff && push;
      end else if (!head_valid_ff) begin
         head_in       = push_data;
         head_valid_in = push;
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

[sv/framed_packet_receiver_top.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver
// Reassembles framed command packets from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one received byte per beat, low byte of each word first.
//   rsp carries at most one result per byte pair: a provisional data word,
//   a frame accept (reply 0x2D) or a frame reject (reply 0xA5) with cause.
//   csr_write_en/csr_index/csr_write_data set the expected start word
//   (index 0) and end word (index 1); write them only while idle.
// Timing:
//   A taken byte sits in the input register; when it moves on, its result,
//   if any, lands in the output register (or the skid entry behind it),
//   which drives rsp.valid. One byte per cycle is sustained while no result
//   finds the queue full; the parse path from input register to result
//   register sets that rate.
// Reset:
//   Synchronous reset drops all valids, restores the register defaults and
//   returns the parser to hunting for a start word on a fresh byte pair.
// Stalls:
//   A held result sits in the output register with a skid entry behind it;
//   req.ready falls only when a byte that produces a result finds both full.
// ----------------------------------------------------------------------------
module framed_packet_receiver_top import fpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   fpr_req_if.sink           req,
   fpr_rsp_if.source         rsp,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_write_data
);

   logic [WORD_W-1:0] start_word_ff;
   logic [WORD_W-1:0] end_word_ff;
   logic              stage_valid_ff;
   logic [BYTE_W-1:0] stage_byte_ff;

   logic              res_valid;
   rsp_type           res;
   logic              q_full;
   logic              advance;
   rsp_type           q_out;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= START_WORD_RESET;
         end_word_ff   <= END_WORD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_WORD: start_word_ff <= csr_write_data;
            CSR_END_WORD:   end_word_ff   <= csr_write_data;
         endcase
      end
   end

   // Input register moves on unless its result finds the queue full
   assign advance   = stage_valid_ff && (!res_valid || !q_full);
   assign req.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         stage_byte_ff <= req.rx_byte;
      end
   end

   fpr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid_ff),
      .in_take    (advance),
      .in_byte    (stage_byte_ff),
      .start_word (start_word_ff),
      .end_word   (end_word_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   fpr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .full      (q_full),
      .out_valid (rsp.valid),
      .out_data  (q_out),
      .out_ready (rsp.ready)
   );

   // Result beat fields
   assign rsp.result_kind   = q_out.result_kind;
   assign rsp.frame_command = q_out.frame_command;
   assign rsp.frame_length  = q_out.frame_length;
   assign rsp.data_word     = q_out.data_word;
   assign rsp.data_index    = q_out.data_index;
   assign rsp.error_cause   = q_out.error_cause;
   assign rsp.reply_byte    = q_out.reply_byte;

endmodule

[sv/fpr_checker.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_packet_receiver_top_defines.svh"

module fpr_checker import fpr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [KIND_W-1:0]  rsp_result_kind,
   input logic [WORD_W-1:0]  rsp_data_word,
   input logic [INDEX_W-1:0] rsp_data_index,
   input logic [CAUSE_W-1:0] rsp_error_cause,
   input logic [BYTE_W-1:0]  rsp_reply_byte
);

   // Data beats carry no verdict
   `FPR_ASSERT(a_data_no_verdict, rsp_valid && rsp_result_kind == KIND_DATA |-> rsp_reply_byte == REPLY_NONE && rsp_error_cause == CAUSE_NONE, "data beat carries a verdict")

   // Accept beats carry the ack reply and no payload word
   `FPR_ASSERT(a_accept_fields, rsp_valid && rsp_result_kind == KIND_ACCEPT |-> rsp_reply_byte == REPLY_ACK && rsp_error_cause == CAUSE_NONE && rsp_data_word == '0 && rsp_data_index == '0, "accept beat fields wrong")

   // Reject beats carry the nak reply and a cause
   `FPR_ASSERT(a_reject_fields, rsp_valid && rsp_result_kind == KIND_REJECT |-> rsp_reply_byte == REPLY_NAK && rsp_error_cause != CAUSE_NONE, "reject beat fields wrong")

   // A stalled beat stays put
   `FPR_ASSERT(a_hold_stalled, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_data_word) && $stable(rsp_data_index), "stalled result beat changed")

   // Nothing is offered right after reset
   `FPR_ASSERT_ALWAYS(a_quiet_after_reset, $past(reset) |-> !rsp_valid, "result offered after reset")

endmodule

bind framed_packet_receiver_top fpr_checker u_fpr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_result_kind (rsp.result_kind),
   .rsp_data_word   (rsp.data_word),
   .rsp_data_index  (rsp.data_index),
   .rsp_error_cause (rsp.error_cause),
   .rsp_reply_byte  (rsp.reply_byte)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Feeds received bytes to the frame parser and checks every data word and
// frame verdict. A directed table covers each verdict and framing corner;
// random frames follow: well formed, corrupted, and noise. Expected results
// come from a bit-accurate parser kept in the testbench. Both sides idle at
// random, the result side holds off long enough to fill the block, and the
// frame markers are changed between phases.
// ----------------------------------------------------------------------------
module tb;
   import fpr_pkg::*;

   localparam int RSP_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_BYTES     = 130;
   localparam int NUM_PHASES      = 5;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              typed;
      rsp_type           want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic              csr_write_en;
   logic              csr_index;
   logic [WORD_W-1:0] csr_write_data;

   fpr_req_if req_if ();
   fpr_rsp_if rsp_if ();

   framed_packet_receiver_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Frame markers as programmed
   logic [WORD_W-1:0] start_marker;
   logic [WORD_W-1:0] end_marker;

   // Parser state mirror
   phase_type          frame_phase;
   logic               pair_high;
   logic [BYTE_W-1:0]  held_low;
   logic [WORD_W-1:0]  frame_len;
   logic [INDEX_W-1:0] words_left;
   logic [INDEX_W-1:0] word_pos;
   logic [WORD_W-1:0]  frame_sum;
   logic [WORD_W-1:0]  frame_cmd;

   rsp_type awaited_results[$];
   rsp_type fixed_results[$];
   int unsigned mismatches;
   int unsigned sent_bytes;
   int unsigned idle_cycles;
   bit quiet_mode;
   bit rsp_hold_req;
   directed_row_type directed_rows[16];

   function automatic rsp_type make_result(input logic [KIND_W-1:0] kind,
                                           input logic [WORD_W-1:0] cmd,
                                           input logic [WORD_W-1:0] len,
                                           input logic [WORD_W-1:0] word,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic [CAUSE_W-1:0] cause,
                                           input logic [BYTE_W-1:0] reply);
      return {kind, cmd, len, word, idx, cause, reply};
   endfunction

   // Advance the parser mirror by one byte; returns 1 when a result is due
   function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output rsp_type r);
      logic [WORD_W-1:0] w;
      r = '0;
      if (!pair_high) begin
         held_low  = b;
         pair_high = 1'b1;
         return 1'b0;
      end
      pair_high = 1'b0;
      w = {b, held_low};
      case (frame_phase)
         PH_LENGTH: begin
            frame_len   = w;
            words_left  = w[15:1];
            word_pos    = '0;
            frame_sum   = '0;
            frame_phase = PH_COMMAND;
            return 1'b0;
         end
         PH_COMMAND: begin
            frame_cmd = w;
            frame_sum = frame_sum + held_low + b;
            if (words_left != 0) frame_phase = PH_DATA;
            else frame_phase = PH_CHECK;
            return 1'b0;
         end
         PH_DATA: begin
            r = make_result(KIND_DATA, frame_cmd, frame_len, w, word_pos, CAUSE_NONE,
                            REPLY_NONE);
            frame_sum  = frame_sum + held_low + b;
            word_pos   = word_pos + 1'b1;
            words_left = words_left - 1'b1;
            if (words_left != 0) frame_phase = PH_DATA;
            else frame_phase = PH_CHECK;
            return 1'b1;
         end
         PH_CHECK: begin
            if (w != frame_sum) begin
               frame_phase = PH_START;
               r = make_result(KIND_REJECT, frame_cmd, frame_len, '0, '0, CAUSE_SUM,
                               REPLY_NAK);
               return 1'b1;
            end
            frame_phase = PH_END;
            return 1'b0;
         end
         PH_END: begin
            frame_phase = PH_START;
            if (w != end_marker)
               r = make_result(KIND_REJECT, frame_cmd, frame_len, '0, '0, CAUSE_END,
                               REPLY_NAK);
            else
               r = make_result(KIND_ACCEPT, frame_cmd, frame_len, '0, '0, CAUSE_NONE,
                               REPLY_ACK);
            return 1'b1;
         end
         default: begin
            if (w != start_marker) begin
               frame_phase = PH_START;
               r = make_result(KIND_REJECT, '0, '0, '0, '0, CAUSE_START, REPLY_NAK);
               return 1'b1;
            end
            frame_phase = PH_LENGTH;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, field, want, got);
      mismatches++;
   endtask

   // Compare one result beat with the oldest expectation
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("unexpected result, kind", 0, got.result_kind);
         return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind != want.result_kind)
         report_mismatch("result_kind", want.result_kind, got.result_kind);
      if (got.frame_command != want.frame_command)
         report_mismatch("frame_command", want.frame_command, got.frame_command);
      if (got.frame_length != want.frame_length)
         report_mismatch("frame_length", want.frame_length, got.frame_length);
      if (got.data_word != want.data_word)
         report_mismatch("data_word", want.data_word, got.data_word);
      if (got.data_index != want.data_index)
         report_mismatch("data_index", want.data_index, got.data_index);
      if (got.error_cause != want.error_cause)
         report_mismatch("error_cause", want.error_cause, got.error_cause);
      if (got.reply_byte != want.reply_byte)
         report_mismatch("reply_byte", want.reply_byte, got.reply_byte);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: predict on each byte beat, check each result beat
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type got;
      bit      produced;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            produced = parse_rx_byte(req_if.rx_byte, predicted);
            if (produced) begin
               if (fixed_results.size() != 0) predicted = fixed_results.pop_front();
               awaited_results.push_back(predicted);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.result_kind, rsp_if.frame_command, rsp_if.frame_length,
                   rsp_if.data_word, rsp_if.data_index, rsp_if.error_cause,
                   rsp_if.reply_byte};
            check_result(got);
         end
      end
   end

   // Watchdog on beats of either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("** framed_packet_receiver_top: FAILED **");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         rsp_if.ready <= quiet_mode || ($urandom_range(99) >= 24);
      end
   end

   // One byte beat, with a random gap ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!quiet_mode && $urandom_range(99) < 24) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      sent_bytes++;
   endtask

   task automatic send_word(input logic [WORD_W-1:0] w);
      send_byte(w[7:0]);
      send_byte(w[15:8]);
   endtask

   // Stop offering bytes until every result is in and the pipe is quiet
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program both frame markers, start word first, then end word
   task automatic write_markers(input logic [WORD_W-1:0] first_word,
                                input logic [WORD_W-1:0] last_word);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_START_WORD;
      csr_write_data <= first_word;
      @(posedge clock);
      csr_index      <= CSR_END_WORD;
      csr_write_data <= last_word;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      start_marker = first_word;
      end_marker   = last_word;
   endtask

   // One random frame, a corrupted one, bad start words or plain noise
   task automatic send_frame(input int unsigned flavor);
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] cmd;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] sum;
      int unsigned       n;
      if (flavor < 78) begin
         if ($urandom_range(19) == 0) len = 16'($urandom_range(60, 13));
         else len = 16'($urandom_range(12));
         cmd = 16'($urandom);
         sum = cmd[7:0] + cmd[15:8];
         send_word(start_marker);
         send_word(len);
         send_word(cmd);
         repeat (len[15:1]) begin
            word = 16'($urandom);
            sum += word[7:0] + word[15:8];
            send_word(word);
         end
         // 60..69: checksum corrupted, 70..77: end word corrupted
         if (flavor >= 60 && flavor < 70) sum += 16'($urandom_range(65535, 1));
         send_word(sum);
         if (flavor >= 70) send_word(end_marker ^ 16'($urandom_range(65535, 1)));
         else if (flavor < 60) send_word(end_marker);
      end else if (flavor < 88) begin
         repeat ($urandom_range(3, 1)) send_word(start_marker ^ 16'($urandom_range(65535, 1)));
      end else begin
         n = $urandom_range(7, 1);
         repeat (n) send_byte(8'($urandom));
         // realign to a byte pair most of the time
         if ((sent_bytes % 2) != 0 && $urandom_range(3) != 0) send_byte(8'($urandom));
      end
   endtask

   // Stimulus
   initial begin
      logic [WORD_W-1:0] marker;
      int unsigned       phase_end;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_START_WORD;
      csr_write_data <= '0;
      mismatches   = 0;
      sent_bytes   = 0;
      quiet_mode   = 1'b0;
      rsp_hold_req = 1'b0;
      start_marker = START_WORD_RESET;
      end_marker   = END_WORD_RESET;
      frame_phase  = PH_START;
      pair_high    = 1'b0;
      held_low     = '0;
      frame_len    = '0;
      words_left   = '0;
      word_pos     = '0;
      frame_sum    = '0;
      frame_cmd    = '0;

      // Directed frames under the reset markers
      directed_rows = '{
         // bad start word
         '{16'h0000, 1'b1, make_result(KIND_REJECT, '0, '0, '0, '0, CAUSE_START,
                                       REPLY_NAK)},
         // odd length, one data word, accepted
         '{START_WORD_RESET, 1'b0, '0},
         '{16'h0003, 1'b0, '0},
         '{16'h0000, 1'b0, '0},
         '{16'hFFFF, 1'b1, make_result(KIND_DATA, 16'h0000, 16'h0003, 16'hFFFF, '0,
                                       CAUSE_NONE, REPLY_NONE)},
         '{16'h01FE, 1'b0, '0},
         '{END_WORD_RESET, 1'b1, make_result(KIND_ACCEPT, 16'h0000, 16'h0003, '0, '0,
                                             CAUSE_NONE, REPLY_ACK)},
         // no data words, checksum wrong
         '{START_WORD_RESET, 1'b0, '0},
         '{16'h0000, 1'b0, '0},
         '{16'hFFFF, 1'b0, '0},
         '{16'h0000, 1'b1, make_result(KIND_REJECT, 16'hFFFF, 16'h0000, '0, '0,
                                       CAUSE_SUM, REPLY_NAK)},
         // length one rounds down to no data, bad end word
         '{START_WORD_RESET, 1'b0, '0},
         '{16'h0001, 1'b0, '0},
         '{16'h1234, 1'b0, '0},
         '{16'h0046, 1'b0, '0},
         '{16'h0000, 1'b1, make_result(KIND_REJECT, 16'h1234, 16'h0001, '0, '0,
                                       CAUSE_END, REPLY_NAK)}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].word[7:0]);
         if (directed_rows[i].typed) fixed_results.push_back(directed_rows[i].want);
         send_byte(directed_rows[i].word[15:8]);
      end

      // Random phases, each under its own pair of markers
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            wait_results_drained();
            marker = 16'($urandom);
            case (p)
               1: write_markers(16'h0000, 16'hFFFF);
               2: write_markers(16'hFFFF, 16'h0000);
               3: write_markers(marker, marker);
               default: write_markers(marker, 16'($urandom));
            endcase
         end
         quiet_mode = (p == 2);
         if (p == 1) begin
            // hold the result side while bytes keep coming
            rsp_hold_req = 1'b1;
            repeat (40) send_byte(8'($urandom));
         end
         phase_end = sent_bytes + PHASE_BYTES;
         while (sent_bytes < phase_end) send_frame($urandom_range(99));
      end
      quiet_mode = 1'b0;

      wait_results_drained();
      if (mismatches == 0)
         $display("** framed_packet_receiver_top: PASSED **");
      else
         $display("** framed_packet_receiver_top: FAILED **");
      $finish;
   end

endmodule
